// ===== sv/nnact_pkg.sv =====
// Package for the activation unit: sizes, codes, state types and the exp table.
// No dependencies.
package nnact_pkg;

  localparam int MAX_ELEMENTS = 4096;
  localparam int MAX_ROW      = 64;
  localparam int SAVED_AW     = $clog2(MAX_ELEMENTS);
  localparam int ROW_AW       = $clog2(MAX_ROW);
  localparam int CNT_W        = $clog2(MAX_ROW + 1);
  localparam int ACC_W        = 31;
  localparam int SUM_W        = ACC_W + ROW_AW;
  localparam int NUM_W        = 43;
  localparam int QUO_W        = 13;
  localparam int ROW_W        = 28;

  typedef enum logic [1:0] {
    MODE_LIN  = 2'd0,
    MODE_SIG  = 2'd1,
    MODE_SMAX = 2'd2,
    MODE_RELU = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_BWD, ST_GRAD1, ST_GRAD2, ST_GRAD3, ST_ROW_RD, ST_ROW_X,
    ST_EXP, ST_MLO, ST_MHI, ST_MACC, ST_DIV, ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    CTX_SIG, CTX_SUM, CTX_OUT
  } ctx_e;

  // exp(-2^(k-12)) in Q30
  function automatic logic [29:0] exp_tab(input logic [3:0] k);
    logic [29:0] t;
    case (k)
      4'd0:    t = 30'd1073479712;
      4'd1:    t = 30'd1073217664;
      4'd2:    t = 30'd1072693760;
      4'd3:    t = 30'd1071646719;
      4'd4:    t = 30'd1069555701;
      4'd5:    t = 30'd1065385899;
      4'd6:    t = 30'd1057095000;
      4'd7:    t = 30'd1040706261;
      4'd8:    t = 30'd1008687096;
      4'd9:    t = 30'd947573834;
      4'd10:   t = 30'd836230973;
      4'd11:   t = 30'd651257337;
      4'd12:   t = 30'd395007542;
      4'd13:   t = 30'd145315154;
      4'd14:   t = 30'd19666268;
      4'd15:   t = 30'd360200;
      default: t = 30'd0;
    endcase
    return t;
  endfunction

endpackage

// ===== sv/nnact_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module nnact_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== sv/nnact_mul.sv =====
// Shared signed 34x17 multiplier with registered product.
// Depends on nothing but the clock.
module nnact_mul (
  input  logic               clk_i,
  input  logic signed [33:0] a_i,
  input  logic signed [16:0] b_i,
  output logic signed [50:0] p_o
);

  always_ff @(posedge clk_i) begin
    p_o <= a_i * b_i;
  end

endmodule

// ===== sv/nnact_div.sv =====
// Restoring divider, one quotient bit per cycle, quotient known to fit QUO_W bits.
// Depends on nnact_pkg.
module nnact_div import nnact_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [SUM_W-1:0] den_i,
  output logic             busy_o,
  output logic [QUO_W-1:0] quo_o
);

  localparam int DSH_W = SUM_W + QUO_W - 1;
  localparam int CW    = $clog2(QUO_W + 1);

  logic             busy_q;
  logic [CW-1:0]    cnt_q;
  logic [NUM_W-1:0] rem_q;
  logic [DSH_W-1:0] dsh_q;
  logic [QUO_W-1:0] quo_q;
  logic             ge;
  logic [DSH_W-1:0] rem_ext;

  assign rem_ext = DSH_W'(rem_q);
  assign ge      = rem_ext >= dsh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(QUO_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      dsh_q <= {den_i, {(QUO_W-1){1'b0}}};
      quo_q <= '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - dsh_q[NUM_W-1:0];
      end
      dsh_q <= dsh_q >> 1;
      quo_q <= {quo_q[QUO_W-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

// ===== sv/nn_activation_unit.sv =====
// Activation unit top level: sequencer, saved-value and row stores, output register.
// Depends on nnact_pkg, nnact_ram, nnact_mul, nnact_div.
//
//  channel  | dir | handshake                  | payload
//  s_axis   | in  | s_axis_tvalid/tready       | tdata value,position; tuser func; tlast row_end
//  m_axis   | out | m_axis_tvalid/tready       | tdata result,result_position; tlast last
//  cfg      | in  | cfg_valid_i/cfg_ready_o    | cfg_data_i mode
//
// Linear/relu forward needs no arithmetic; backward reads the saved value and, for sigmoid,
// runs two multiplies. exp uses the shared multiplier for each set bit of the argument.
// Sigmoid forward: exp, then division. Softmax: the row is stored, then an exp per element
// for the sum, then an exp and a division per element, plus output stalls.
// Reset clears mode, row count and row max; no input is taken while the sequencer works.
// One output register: the next item is taken while a result waits.
module nn_activation_unit import nnact_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] value, [27:16] position
  input  logic        s_axis_tuser,   // func
  input  logic        s_axis_tlast,   // row_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] result, [27:16] result_position
  output logic        m_axis_tlast,   // last
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_data_i
);

  state_e st_q, st_d;
  ctx_e   ctx_q, ctx_d;
  mode_e  mode_q;

  logic signed [15:0] val_q, val_d, sv_q, sv_d, max_q, max_d, res_q, res_d;
  logic [11:0]        pos_q, pos_d;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [15:0]        arg_q, arg_d;
  logic [4:0]         k_q, k_d;
  logic [45:0]        plo_q, plo_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [ROW_AW-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               last_q, last_d;

  logic               ov_q, ov_d;
  logic [15:0]        ores_q, ores_d;
  logic [11:0]        opos_q, opos_d;
  logic               olast_q, olast_d;

  logic               acc_in, emit;
  logic signed [15:0] in_val;
  logic [11:0]        in_pos;

  logic               sv_we;
  logic [SAVED_AW-1:0] sv_waddr;
  logic [15:0]        sv_wdata, sv_rdata;
  logic               rb_we;
  logic [ROW_W-1:0]   rb_rdata;

  logic signed [33:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [50:0] mul_p;

  logic               div_start, div_busy;
  logic [NUM_W-1:0]   div_num;
  logic [SUM_W-1:0]   div_den;
  logic [QUO_W-1:0]   div_q;

  logic [29:0]        tab;
  logic [61:0]        acc_sum;
  logic [48:0]        gp, gmag;
  logic [24:0]        gr;
  logic signed [16:0] xdiff;
  logic [ACC_W:0]     sig_den;

  assign in_val        = s_axis_tdata[15:0];
  assign in_pos        = s_axis_tdata[27:16];
  assign s_axis_tready = (st_q == ST_IDLE);
  assign acc_in        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign tab     = exp_tab(k_q[3:0]);
  assign acc_sum = 62'(plo_q) + {1'b0, mul_p[45:0], 15'd0} + 62'(1 << 29);
  assign gp      = mul_p[48:0];
  assign gmag    = gp[48] ? (49'd0 - gp) : gp;
  assign gr      = 25'((gmag + 49'(1 << 23)) >> 24);
  assign xdiff   = 17'(max_q) - 17'(signed'(rb_rdata[15:0]));
  assign sig_den = (ACC_W+1)'(1 << 30) + (ACC_W+1)'(acc_q);

  nnact_ram #(.WIDTH(16), .DEPTH(MAX_ELEMENTS)) u_saved (
    .clk_i   (clk_i),
    .we_i    (sv_we),
    .waddr_i (sv_waddr),
    .wdata_i (sv_wdata),
    .raddr_i (in_pos[SAVED_AW-1:0]),
    .rdata_o (sv_rdata)
  );

  nnact_ram #(.WIDTH(ROW_W), .DEPTH(MAX_ROW)) u_row (
    .clk_i   (clk_i),
    .we_i    (rb_we),
    .waddr_i (cnt_q[ROW_AW-1:0]),
    .wdata_i ({in_pos, in_val}),
    .raddr_i (idx_q),
    .rdata_o (rb_rdata)
  );

  nnact_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  nnact_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quo_o   (div_q)
  );

  always_comb begin
    st_d = st_q; ctx_d = ctx_q; val_d = val_q; sv_d = sv_q; max_d = max_q;
    res_d = res_q; pos_d = pos_q; acc_d = acc_q; arg_d = arg_q; k_d = k_q;
    plo_d = plo_q; sum_d = sum_q; idx_d = idx_q; cnt_d = cnt_q; last_d = last_q;
    sv_we = 1'b0; sv_waddr = in_pos[SAVED_AW-1:0]; sv_wdata = in_val;
    rb_we = 1'b0; emit = 1'b0;
    mul_a = '0; mul_b = '0;
    div_start = 1'b0; div_num = '0; div_den = '0;

    case (st_q)
      ST_IDLE: begin
        if (acc_in) begin
          val_d  = in_val;
          pos_d  = in_pos;
          last_d = 1'b1;
          ctx_d  = CTX_SIG;
          if (s_axis_tuser) begin
            st_d = ST_BWD;
          end else begin
            sv_we = 1'b1;
            case (mode_q)
              MODE_LIN: begin
                res_d = in_val;
                st_d  = ST_EMIT;
              end
              MODE_RELU: begin
                res_d = in_val[15] ? 16'sd0 : in_val;
                st_d  = ST_EMIT;
              end
              MODE_SIG: begin
                arg_d = in_val[15] ? 16'(-17'(in_val)) : in_val;
                acc_d = ACC_W'(1 << 30);
                k_d   = '0;
                st_d  = ST_EXP;
              end
              default: begin
                rb_we = 1'b1;
                cnt_d = cnt_q + 1'b1;
                if (in_val > max_q) begin
                  max_d = in_val;
                end
                if (s_axis_tlast || cnt_d == CNT_W'(MAX_ROW)) begin
                  idx_d = '0;
                  sum_d = '0;
                  ctx_d = CTX_SUM;
                  st_d  = ST_ROW_RD;
                end
              end
            endcase
          end
        end
      end
      ST_BWD: begin
        sv_d = sv_rdata;
        if (mode_q == MODE_SIG) begin
          st_d = ST_GRAD1;
        end else begin
          res_d = (mode_q == MODE_RELU && sv_rdata[15]) ? 16'sd0 : val_q;
          st_d  = ST_EMIT;
        end
      end
      ST_GRAD1: begin
        mul_a = 34'(val_q);
        mul_b = 17'sd4096 - 17'(sv_q);
        st_d  = ST_GRAD2;
      end
      ST_GRAD2: begin
        mul_a = mul_p[33:0];
        mul_b = 17'(sv_q);
        st_d  = ST_GRAD3;
      end
      ST_GRAD3: begin
        if (gp[48]) begin
          res_d = (gr > 25'd32768) ? -16'sd32768 : 16'(25'd0 - gr);
        end else begin
          res_d = (gr > 25'd32767) ? 16'sd32767 : 16'(gr);
        end
        st_d = ST_EMIT;
      end
      ST_ROW_RD: begin
        st_d = ST_ROW_X;
      end
      ST_ROW_X: begin
        pos_d = rb_rdata[27:16];
        arg_d = xdiff[15:0];
        acc_d = ACC_W'(1 << 30);
        k_d   = '0;
        st_d  = ST_EXP;
      end
      ST_EXP: begin
        if (k_q[4]) begin
          case (ctx_q)
            CTX_SUM: begin
              sum_d = sum_q + SUM_W'(acc_q);
              if (32'(idx_q) + 32'd1 == 32'(cnt_q)) begin
                idx_d = '0;
                ctx_d = CTX_OUT;
              end else begin
                idx_d = idx_q + 1'b1;
              end
              st_d = ST_ROW_RD;
            end
            CTX_OUT: begin
              div_start = 1'b1;
              div_num   = NUM_W'({acc_q, 12'd0}) + NUM_W'(sum_q >> 1);
              div_den   = sum_q;
              st_d      = ST_DIV;
            end
            default: begin
              div_start = 1'b1;
              div_num   = (val_q[15] ? NUM_W'({acc_q, 12'd0}) : NUM_W'(64'd1 << 42))
                          + NUM_W'(sig_den >> 1);
              div_den   = SUM_W'(sig_den);
              st_d      = ST_DIV;
            end
          endcase
        end else if (arg_q[k_q[3:0]]) begin
          st_d = ST_MLO;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_MLO: begin
        mul_a = 34'(acc_q);
        mul_b = 17'(tab[14:0]);
        st_d  = ST_MHI;
      end
      ST_MHI: begin
        plo_d = mul_p[45:0];
        mul_a = 34'(acc_q);
        mul_b = 17'(tab[29:15]);
        st_d  = ST_MACC;
      end
      ST_MACC: begin
        acc_d = acc_sum[60:30];
        k_d   = k_q + 1'b1;
        st_d  = ST_EXP;
      end
      ST_DIV: begin
        if (!div_busy) begin
          res_d = 16'(div_q);
          if (ctx_q == CTX_OUT) begin
            last_d = (32'(idx_q) + 32'd1 == 32'(cnt_q));
          end else begin
            sv_we    = 1'b1;
            sv_waddr = pos_q[SAVED_AW-1:0];
            sv_wdata = 16'(div_q);
          end
          st_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!ov_q || m_axis_tready) begin
          emit = 1'b1;
          if (ctx_q == CTX_OUT && !last_q) begin
            idx_d = idx_q + 1'b1;
            st_d  = ST_ROW_RD;
          end else begin
            if (ctx_q == CTX_OUT) begin
              cnt_d = '0;
              max_d = -16'sd32768;
            end
            st_d = ST_IDLE;
          end
        end
      end
      default: st_d = ST_IDLE;
    endcase

    if (cfg_valid_i) begin
      cnt_d = '0;
      max_d = -16'sd32768;
    end
  end

  always_comb begin
    ov_d = ov_q; ores_d = ores_q; opos_d = opos_q; olast_d = olast_q;
    if (ov_q && m_axis_tready) begin
      ov_d = 1'b0;
    end
    if (emit) begin
      ov_d    = 1'b1;
      ores_d  = res_q;
      opos_d  = pos_q;
      olast_d = last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      ctx_q  <= CTX_SIG;
      mode_q <= MODE_LIN;
      cnt_q  <= '0;
      max_q  <= -16'sd32768;
      ov_q   <= 1'b0;
    end else begin
      st_q  <= st_d;
      ctx_q <= ctx_d;
      cnt_q <= cnt_d;
      max_q <= max_d;
      ov_q  <= ov_d;
      if (cfg_valid_i) begin
        mode_q <= mode_e'(cfg_data_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q   <= val_d;
    sv_q    <= sv_d;
    res_q   <= res_d;
    pos_q   <= pos_d;
    acc_q   <= acc_d;
    arg_q   <= arg_d;
    k_q     <= k_d;
    plo_q   <= plo_d;
    sum_q   <= sum_d;
    idx_q   <= idx_d;
    last_q  <= last_d;
    ores_q  <= ores_d;
    opos_q  <= opos_d;
    olast_q <= olast_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {4'd0, opos_q, ores_q};
  assign m_axis_tlast  = olast_q;

endmodule

// ===== bench/nnact_checker.sv =====
// Scoreboard for the activation unit: watches input, config and output transfers,
// predicts each result in Q4.12 and compares it with what comes out.
// Depends on nnact_pkg for the sizes and the mode codes.
module nnact_checker import nnact_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] value, [27:16] position
  input  logic        s_axis_tuser,   // func
  input  logic        s_axis_tlast,   // row_end
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,   // [15:0] result, [27:16] result_position
  input  logic        m_axis_tlast,   // last
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [1:0]  cfg_data_i,
  output int          pending_o,
  output int          errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] result;
    logic [11:0] pos;
    logic        last;
  } act_result_t;

  localparam longint unsigned ONE_Q30 = 64'd1073741824;

  // exp(-2^(k-12)) in Q30
  localparam longint unsigned EXP_STEP [16] = '{
    64'd1073479712, 64'd1073217664, 64'd1072693760, 64'd1071646719,
    64'd1069555701, 64'd1065385899, 64'd1057095000, 64'd1040706261,
    64'd1008687096, 64'd947573834,  64'd836230973,  64'd651257337,
    64'd395007542,  64'd145315154,  64'd19666268,   64'd360200
  };

  mode_e             act_mode;
  logic signed [15:0] saved_act [MAX_ELEMENTS];
  logic signed [15:0] row_val [MAX_ROW];
  logic [11:0]        row_pos [MAX_ROW];
  int                 row_len;
  int                 row_peak;
  act_result_t        expected_results [$];
  int                 n_err;

  function automatic longint unsigned neg_exp(logic [15:0] a);
    longint unsigned acc;
    acc = ONE_Q30;
    for (int k = 0; k < 16; k++)
      if (a[k]) acc = (acc * EXP_STEP[k] + (ONE_Q30 >> 1)) >> 30;
    return acc;
  endfunction

  function automatic int sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  function automatic int sigmoid_q(int x);
    longint unsigned e, den, num;
    e   = neg_exp(16'(x < 0 ? -x : x));
    den = ONE_Q30 + e;
    num = (x >= 0) ? (64'd4096 << 30) : (64'd4096 * e);
    return int'((num + den / 2) / den);
  endfunction

  function automatic int grad_round(longint p);
    longint unsigned m;
    longint r;
    m = (p < 0) ? longint'(-p) : p;
    r = longint'((m + (64'd1 << 23)) >> 24);
    return sat16(p < 0 ? -r : r);
  endfunction

  task automatic push_result(int r, logic [11:0] pos, logic last);
    act_result_t e;
    e.result = r[15:0];
    e.pos    = pos;
    e.last   = last;
    expected_results = {expected_results, e};
  endtask

  task automatic flush_row();
    longint unsigned sum;
    sum = 0;
    for (int i = 0; i < row_len; i++) sum += neg_exp(16'(row_peak - row_val[i]));
    if (sum == 0) sum = 1;
    for (int i = 0; i < row_len; i++)
      push_result(int'((64'd4096 * neg_exp(16'(row_peak - row_val[i])) + sum / 2) / sum),
                  row_pos[i], i + 1 == row_len);
    row_len  = 0;
    row_peak = -32768;
  endtask

  task automatic activation_predict(logic func, logic signed [15:0] v, logic [11:0] pos,
                                    logic row_end);
    int s, y;
    if (func) begin
      s = saved_act[pos];
      if (act_mode == MODE_SIG)
        push_result(grad_round(longint'(v) * longint'(4096 - s) * longint'(s)), pos, 1'b1);
      else if (act_mode == MODE_RELU && s < 0)
        push_result(0, pos, 1'b1);
      else
        push_result(v, pos, 1'b1);
    end else begin
      saved_act[pos] = v;
      case (act_mode)
        MODE_LIN:  push_result(v, pos, 1'b1);
        MODE_RELU: push_result(v < 0 ? 0 : int'(v), pos, 1'b1);
        MODE_SIG: begin
          y = sigmoid_q(v);
          saved_act[pos] = y[15:0];
          push_result(y, pos, 1'b1);
        end
        default: begin
          if (row_len < MAX_ROW) begin
            row_val[row_len] = v;
            row_pos[row_len] = pos;
            row_len++;
            if (v > row_peak) row_peak = v;
          end
          if (row_end || row_len >= MAX_ROW) flush_row();
        end
      endcase
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    act_result_t got, want;
    if (!rst_ni) begin
      act_mode  = MODE_LIN;
      row_len   = 0;
      row_peak  = -32768;
      n_err     = 0;
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata[15:0], m_axis_tdata[27:16], m_axis_tlast};
        if (expected_results.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected result %h pos %0d last %b",
                                    got.result, got.pos, got.last);
        end else begin
          want = expected_results.pop_front();
          if (got != want) begin
            n_err++;
            if (n_err <= 10)
              $display("mismatch: exp %h pos %0d last %b, got %h pos %0d last %b",
                       want.result, want.pos, want.last, got.result, got.pos, got.last);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        act_mode = mode_e'(cfg_data_i);
        row_len  = 0;
        row_peak = -32768;
      end
      if (s_axis_tvalid && s_axis_tready)
        activation_predict(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[27:16],
                           s_axis_tlast);
      pending_o <= expected_results.size();
      errors_o  <= n_err;
    end
  end

endmodule

// ===== bench/tb.sv =====
// Top of the activation unit bench: clock, reset, stimulus and verdict.
// Depends on nnact_pkg, nn_activation_unit and nnact_checker.
module tb import nnact_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN       = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_data_i = '0;
  int          pending, errors;
  bit          idle_on = 1'b1;
  int          cycles = 0;
  logic [11:0] written_pos [$];
  mode_e       cur_mode;

  nn_activation_unit i_dut (.*);

  nnact_checker i_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .s_axis_tlast, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i, .pending_o(pending), .errors_o(errors)
  );

  initial forever #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[nn_activation_unit] ERROR");
      $finish;
    end
  end

  initial begin
    int n;
    forever begin
      @(negedge clk_i);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 5);
        m_axis_tready = 1'b0;
        repeat (n) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
    end
  end

  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN) @(negedge clk_i);
  endtask

  task automatic set_mode(mode_e m);
    drain();
    cfg_valid_i = 1'b1;
    cfg_data_i  = m;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    cur_mode = m;
  endtask

  task automatic send(logic func, logic [15:0] v, logic [11:0] pos, logic row_end);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {4'd0, pos, v};
    s_axis_tuser  = func;
    s_axis_tlast  = row_end;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    if (!func) written_pos = {written_pos, pos};
  endtask

  function automatic logic [11:0] old_pos();
    return written_pos[$urandom_range(0, written_pos.size() - 1)];
  endfunction

  function automatic logic [15:0] rand_value();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(0, 8191) - 4096);
      2:       return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: return 16'($urandom_range(0, 1023) - 512);
    endcase
  endfunction

  task automatic random_item(bit closing_row);
    if (written_pos.size() != 0 && $urandom_range(0, 9) < 3)
      send(1'b1, rand_value(), old_pos(), 1'($urandom));
    else
      send(1'b0, rand_value(), 12'($urandom), closing_row);
  endtask

  initial begin
    int len;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // linear, plus out-of-range saved value for sigmoid later
    set_mode(MODE_LIN);
    send(1'b0, 16'h7fff, 12'd0, 1'b0);
    send(1'b0, 16'h8000, 12'd4095, 1'b1);
    send(1'b1, 16'h8000, 12'd0, 1'b0);
    send(1'b1, 16'h7fff, 12'd4095, 1'b1);
    set_mode(MODE_SIG);
    send(1'b1, 16'h7fff, 12'd0, 1'b0);
    send(1'b1, 16'h8000, 12'd4095, 1'b0);
    send(1'b0, 16'h0000, 12'd1, 1'b0);
    send(1'b0, 16'h7fff, 12'd2, 1'b0);
    send(1'b0, 16'h8000, 12'd3, 1'b0);
    send(1'b0, 16'hf800, 12'd4, 1'b0);
    send(1'b1, 16'h7fff, 12'd1, 1'b0);
    send(1'b1, 16'h8000, 12'd4, 1'b0);
    set_mode(MODE_RELU);
    send(1'b0, 16'hffff, 12'd5, 1'b0);
    send(1'b0, 16'h0001, 12'd6, 1'b0);
    send(1'b1, 16'h7fff, 12'd5, 1'b0);
    send(1'b1, 16'h8000, 12'd6, 1'b0);
    set_mode(MODE_SMAX);
    send(1'b0, 16'h7fff, 12'd7, 1'b0);
    send(1'b1, 16'h1234, 12'd7, 1'b0);
    send(1'b0, 16'h8000, 12'd8, 1'b0);
    send(1'b0, 16'h0100, 12'd9, 1'b1);
    for (int i = 0; i < 64; i++) send(1'b0, 16'($urandom_range(0, 4095)), 12'(i), 1'b0);
    send(1'b0, 16'h0400, 12'd100, 1'b0);
    set_mode(MODE_SMAX);

    for (int ph = 0; ph < 12; ph++) begin
      if (ph >= 9) idle_on = 1'b0;
      set_mode(ph < 4 ? mode_e'(ph) : mode_e'($urandom_range(0, 3)));
      if (cur_mode == MODE_SMAX) begin
        for (int r = 0; r < 5; r++) begin
          len = $urandom_range(0, 15) == 0 ? 64 : $urandom_range(1, 6);
          for (int i = 0; i < len; i++) random_item(i == len - 1);
        end
      end else begin
        for (int i = 0; i < 20; i++) random_item(1'($urandom));
      end
      if (ph == 5) drain();
    end

    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("[nn_activation_unit] OK");
    end else begin
      $display("[nn_activation_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== nn_activation_unit.f =====
sv/nnact_pkg.sv
sv/nnact_ram.sv
sv/nnact_mul.sv
sv/nnact_div.sv
sv/nn_activation_unit.sv
bench/nnact_checker.sv
bench/tb.sv
